// ===== hdl/rfe_pkg.sv =====
// Package for the flow RTT flight estimator.
// Holds field widths, register codes, reset values and the shared types.
// No dependencies.
package rfe_pkg;

    // Field and state widths
    localparam int TS_SEC_W   = 32;
    localparam int TS_US_W    = 20;
    localparam int IAT_W      = 31;
    localparam int SAMPLE_W   = 33;
    localparam int RATIO_W    = 12;
    localparam int GAP_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int HIST_DEPTH = 3;
    localparam int HCNT_W     = 2;
    localparam int FLIGHT_W   = 8;

    // Arithmetic constants
    localparam int US_PER_S     = 1000000;
    localparam int FLIGHT_LIMIT = 3;
    localparam logic [FLIGHT_W-1:0] FLIGHT_MAX = 8'd255;
    localparam logic [HCNT_W-1:0]   HCNT_MAX   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 1'b1;

    // Configuration reset values
    localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd26;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 24'd1000;

    typedef logic [IAT_W-1:0] iat_t;
    typedef iat_t [HIST_DEPTH-1:0] hist_t;

    typedef struct packed {
        logic [TS_SEC_W-1:0] seconds;
        logic [TS_US_W-1:0]  micros;
    } ts_t;

    // Outcome of one packet, from the step logic to the state registers
    typedef struct packed {
        logic                ignore;
        iat_t                cur;
        logic [SAMPLE_W-1:0] sample;
        logic [FLIGHT_W-1:0] flight_next;
        logic [HCNT_W-1:0]   count_next;
    } step_t;

endpackage

// ===== hdl/flow_rtt_flight_estimator_unit.sv =====
// Top level of the flow RTT flight estimator: handshakes, config
// registers, flight state and IAT history. Depends on rfe_pkg and
// rfe_step_logic.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_stall, ts_seconds, ts_micros  | in
//  result  | out_valid, out_stall, rtt_sample_us        | out
//  config  | cfg_wen, cfg_index, cfg_data               | in
//
// One packet per cycle sustained while the result side is not stalled; a packet
// passes through the input register, then its result is loaded into the result
// register, from which it transfers out. Every transfer in gives one result.
// rst_n clears config to defaults and flight state to zero; history has no reset.
// An input register and the result register part the two sides, so a packet
// is taken while a result waits; in_stall rises only when both are full and
// the result is stalled.
module flow_rtt_flight_estimator_unit #(
    parameter int RTT_FLIGHT_LIMIT = rfe_pkg::FLIGHT_LIMIT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rfe_pkg::TS_SEC_W-1:0]       ts_seconds,
    input  logic [rfe_pkg::TS_US_W-1:0]        ts_micros,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rfe_pkg::SAMPLE_W-1:0]       rtt_sample_us,
    input  logic                               cfg_wen,
    input  logic [rfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfe_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rfe_pkg::*;

    logic                  in_valid_reg;
    ts_t                   ts_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [RATIO_W-1:0]    ratio_reg;
    logic [GAP_W-1:0]      gap_reg;
    ts_t                   last_reg;
    hist_t                 hist_reg;
    logic [HCNT_W-1:0]     count_reg;
    logic [FLIGHT_W-1:0]   flight_reg;
    step_t                 step;
    logic                  advance;
    logic                  fire;
    logic                  in_xfer;

    // Handshake control
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;
    assign fire     = in_valid_reg && advance;

    assign out_valid     = out_valid_reg;
    assign rtt_sample_us = sample_reg;

    rfe_step_logic #(
        .RTT_FLIGHT_LIMIT (RTT_FLIGHT_LIMIT)
    ) u_step (
        .ts               (ts_reg),
        .last_ts          (last_reg),
        .hist             (hist_reg),
        .hist_count       (count_reg),
        .flight_len       (flight_reg),
        .ratio_threshold  (ratio_reg),
        .gap_threshold_us (gap_reg),
        .res              (step)
    );

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            gap_reg   <= GAP_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_RATIO: ratio_reg <= cfg_data[RATIO_W-1:0];
                CFG_GAP:   gap_reg   <= cfg_data[GAP_W-1:0];
                default:   ;
            endcase
        end
    end

    // Valid flags and flight state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            count_reg     <= '0;
            flight_reg    <= '0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (fire && !step.ignore)
            begin
                last_reg   <= ts_reg;
                count_reg  <= step.count_next;
                flight_reg <= step.flight_next;
            end
        end
    end

    // Payload registers and IAT history, newest at entry 0
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ts_reg.seconds <= ts_seconds;
            ts_reg.micros  <= ts_micros;
        end
        if (fire)
            sample_reg <= step.sample;
        if (fire && !step.ignore)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
                hist_reg[i] <= hist_reg[i-1];
            hist_reg[0] <= step.cur;
        end
    end

endmodule

// ===== hdl/rfe_step_logic.sv =====
// Per-packet datapath of the flow RTT flight estimator: IAT, flight
// decision, RTT sample sum and next flight state. Purely combinational.
// Depends on rfe_pkg.
module rfe_step_logic #(
    parameter int RTT_FLIGHT_LIMIT = rfe_pkg::FLIGHT_LIMIT
) (
    input  rfe_pkg::ts_t                      ts,
    input  rfe_pkg::ts_t                      last_ts,
    input  rfe_pkg::hist_t                    hist,
    input  logic [rfe_pkg::HCNT_W-1:0]        hist_count,
    input  logic [rfe_pkg::FLIGHT_W-1:0]      flight_len,
    input  logic [rfe_pkg::RATIO_W-1:0]       ratio_threshold,
    input  logic [rfe_pkg::GAP_W-1:0]         gap_threshold_us,
    output rfe_pkg::step_t                    res
);
    import rfe_pkg::*;

    localparam int SEC_DW  = TS_SEC_W + 2;
    localparam int US_DW   = TS_US_W + 2;
    localparam int FULL_W  = 56;
    localparam int CMP_W   = RATIO_W + IAT_W;

    logic signed [SEC_DW-1:0]  dsec;
    logic signed [US_DW-1:0]   dus;
    logic signed [FULL_W-1:0]  iat_full;
    logic                      sat;
    iat_t                      cur;
    iat_t                      prev;
    iat_t                      diff;
    logic [CMP_W-1:0]          lhs;
    logic [CMP_W-1:0]          rhs;
    logic                      small_change;
    logic                      join_flight;
    logic                      first;
    logic [HCNT_W-1:0]         n;
    logic [SAMPLE_W-1:0]       acc;
    logic                      emit;

    // Inter-arrival time in microseconds, signed, then saturated
    always_comb
    begin
        dsec = $signed({2'b00, ts.seconds}) - $signed({2'b00, last_ts.seconds});
        dus  = $signed({2'b00, ts.micros}) - $signed({2'b00, last_ts.micros});
        iat_full = FULL_W'(dsec) * $signed(FULL_W'(US_PER_S)) + FULL_W'(dus);
        sat = iat_full > $signed(FULL_W'({IAT_W{1'b1}}));
        cur = sat ? {IAT_W{1'b1}} : iat_full[IAT_W-1:0];
    end

    // Flight decision: relative change against previous IAT, or short gap
    always_comb
    begin
        first = (hist_count == '0);
        prev  = hist[0];
        diff  = (cur >= prev) ? (cur - prev) : (prev - cur);
        lhs   = CMP_W'({diff, 8'b0});
        rhs   = {{IAT_W{1'b0}}, ratio_threshold} * {{RATIO_W{1'b0}}, prev};
        if (prev == '0)
            small_change = (ratio_threshold != '0);
        else
            small_change = (lhs < rhs);
        join_flight = small_change || (cur < IAT_W'(gap_threshold_us));
    end

    // RTT sample: stored IATs of the flight plus the current one
    always_comb
    begin
        if (flight_len > FLIGHT_W'(hist_count))
            n = hist_count;
        else
            n = flight_len[HCNT_W-1:0];
        acc = SAMPLE_W'(cur);
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            if (HCNT_W'(i) < n)
                acc = acc + SAMPLE_W'(hist[i]);
        end
        emit = !first && !join_flight && (flight_len <= FLIGHT_W'(RTT_FLIGHT_LIMIT));
    end

    // Result and next state
    always_comb
    begin
        res.ignore = (iat_full <= 0);
        res.cur    = cur;
        res.sample = (!res.ignore && emit) ? acc : '0;
        if (first)
            res.flight_next = flight_len;
        else if (join_flight)
            res.flight_next = (flight_len == FLIGHT_MAX) ? flight_len : flight_len + 1'b1;
        else
            res.flight_next = '0;
        res.count_next = (hist_count == HCNT_MAX) ? hist_count : hist_count + 1'b1;
    end

endmodule

// ===== verif/flow_rtt_flight_estimator_unit_tb.sv =====
// Testbench for flow_rtt_flight_estimator_unit: directed timestamps, then random
// packet flights with noise, under several threshold settings and random idling.
// Depends on rfe_pkg and the flow_rtt_flight_estimator_unit RTL.
import rfe_pkg::*;

// Tracks flight state per packet and holds the RTT samples still due
class rtt_flight_tracker;
    localparam longint IAT_SAT = (longint'(1) << IAT_W) - 1;

    logic [RATIO_W-1:0]  ratio;
    logic [GAP_W-1:0]    gap_us;
    logic [TS_SEC_W-1:0] last_sec;
    logic [TS_US_W-1:0]  last_us;
    iat_t                iat_hist [HIST_DEPTH];
    int unsigned         hist_count;
    int unsigned         flight_len;
    logic [SAMPLE_W-1:0] rtt_due [$];
    int                  mismatch_count;

    function new();
        ratio          = RATIO_RESET;
        gap_us         = GAP_RESET;
        last_sec       = '0;
        last_us        = '0;
        hist_count     = 0;
        flight_len     = 0;
        mismatch_count = 0;
        foreach (iat_hist[i])
            iat_hist[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_RATIO)
            ratio = data[RATIO_W-1:0];
        else if (idx == CFG_GAP)
            gap_us = data[GAP_W-1:0];
    endfunction

    // One accepted packet: update flight state and queue its sample
    function void take_packet(logic [TS_SEC_W-1:0] sec, logic [TS_US_W-1:0] us);
        longint              delta;
        longint unsigned     c64, p64, r64, diff;
        iat_t                cur;
        logic [SAMPLE_W-1:0] sample;
        bit                  joins;
        int unsigned         n, i;

        delta = (longint'({32'b0, sec}) - longint'({32'b0, last_sec})) * US_PER_S
              + (longint'({44'b0, us}) - longint'({44'b0, last_us}));
        sample = '0;
        // zero or backwards gap leaves the state alone
        if (delta > 0) begin
            cur = (delta > IAT_SAT) ? IAT_SAT[IAT_W-1:0] : delta[IAT_W-1:0];
            if (hist_count != 0) begin
                c64 = cur;
                p64 = iat_hist[0];
                r64 = ratio;
                diff = (c64 >= p64) ? c64 - p64 : p64 - c64;
                if (p64 == 0)
                    joins = (ratio != 0);
                else
                    joins = ((diff << 8) < r64 * p64);
                if (joins || cur < gap_us) begin
                    if (flight_len < FLIGHT_MAX)
                        flight_len++;
                end else begin
                    // short flight ends: sum its stored gaps plus this one
                    if (flight_len <= FLIGHT_LIMIT) begin
                        n = (flight_len < hist_count) ? flight_len : hist_count;
                        for (i = 0; i < n; i++)
                            sample = sample + SAMPLE_W'(iat_hist[i]);
                        sample = sample + SAMPLE_W'(cur);
                    end
                    flight_len = 0;
                end
            end
            iat_hist[2] = iat_hist[1];
            iat_hist[1] = iat_hist[0];
            iat_hist[0] = cur;
            if (hist_count < HIST_DEPTH)
                hist_count++;
            last_sec = sec;
            last_us  = us;
        end
        rtt_due.push_back(sample);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] got);
        logic [SAMPLE_W-1:0] want;
        if (rtt_due.size() == 0) begin
            $display("%0t: unexpected rtt_sample_us transfer, expected none, actual %0d",
                     $time, got);
            mismatch_count++;
        end else begin
            want = rtt_due.pop_front();
            if (got !== want) begin
                $display("%0t: rtt_sample_us mismatch, expected %0d, actual %0d",
                         $time, want, got);
                mismatch_count++;
            end
        end
    endfunction
endclass

module flow_rtt_flight_estimator_unit_tb;
    localparam int HOLD_CYCLES = 80;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [TS_SEC_W-1:0]   ts_seconds = '0;
    logic [TS_US_W-1:0]    ts_micros = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   rtt_sample_us;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rtt_flight_tracker tracker = new();
    bit     in_idle = 1'b1;
    bit     out_idle = 1'b1;
    bit     hold_req = 1'b0;
    int     sent_count = 0;
    longint now_us = 0;

    flow_rtt_flight_estimator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ts_seconds    (ts_seconds),
        .ts_micros     (ts_micros),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rtt_sample_us (rtt_sample_us),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one packet, after a random idle gap if in_idle is set, and wait for its transfer
    task automatic send_packet(input logic [TS_SEC_W-1:0] sec, input logic [TS_US_W-1:0] us);
        int  gap;
        bit  taken;
        gap = in_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        ts_seconds <= sec;
        ts_micros  <= us;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        tracker.take_packet(sec, us);
        sent_count++;
    endtask

    task automatic send_at(input longint t);
        send_packet(32'(t / US_PER_S), 20'(t % US_PER_S));
    endtask

    // Sender clock follows the last packet that the block did not ignore
    task automatic resync();
        now_us = longint'({32'b0, tracker.last_sec}) * US_PER_S + tracker.last_us;
    endtask

    // A break gap, then pkts-1 packets with near-steady spacing
    task automatic send_flight(input int pkts);
        int step, base, jit, i;
        if ($urandom_range(0, 15) == 0)
            now_us += 64'h8000_0000 + $urandom_range(0, 1 << 20);
        else
            now_us += $urandom_range(20000, 3000000);
        send_at(now_us);
        base = $urandom_range(20, 4000);
        for (i = 1; i < pkts; i++)
        begin
            jit  = $urandom_range(0, base / 40);
            step = $urandom_range(0, 1) ? base + jit : base - jit;
            now_us += step;
            send_at(now_us);
        end
    endtask

    // Random timestamps, repeats, backwards steps and out-of-range micros
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_packet($urandom, TS_US_W'($urandom_range(0, 20'hFFFFF)));
            1: send_packet(tracker.last_sec, tracker.last_us);
            2:
            begin
                if (now_us > 5000)
                    send_at(now_us - $urandom_range(1, 5000));
                else
                    send_packet(tracker.last_sec, tracker.last_us);
            end
            default: send_packet(tracker.last_sec,
                                 TS_US_W'($urandom_range(1000000, 20'hFFFFF)));
        endcase
        resync();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all results, then change both thresholds
    task automatic reconfigure(input logic [RATIO_W-1:0] ratio, input logic [GAP_W-1:0] gap);
        in_valid <= 1'b0;
        while (tracker.rtt_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(CFG_RATIO, CFG_DATA_W'(ratio));
        write_reg(CFG_GAP, gap);
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent_count + count;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                in_idle  = $urandom_range(0, 2) != 0;
                out_idle = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(0, 99) < 85)
                send_flight(($urandom_range(0, 7) == 0) ? $urandom_range(6, 12)
                                                        : $urandom_range(1, 5));
            else
                send_noise();
        end
    endtask

    // Result side: random stall per transfer, one long hold-off on request
    initial
    begin
        int                  stall_cycles;
        bit                  got;
        logic [SAMPLE_W-1:0] sample;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                stall_cycles = HOLD_CYCLES;
                hold_req = 1'b0;
            end else
                stall_cycles = out_idle ? $urandom_range(0, 7) : 0;
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got    = out_valid;
                sample = rtt_sample_us;
                @(posedge clk);
            end while (!got);
            tracker.check_sample(sample);
        end
    end

    // Main sequence
    initial
    begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, zero and backwards gaps, odd micros, long flight,
        // saturation of the gap at the far end of the seconds range
        send_packet(32'd0, 20'd0);
        send_packet(32'd0, 20'd100);
        send_packet(32'd0, 20'd200);
        send_packet(32'd0, 20'd300);
        send_packet(32'd1, 20'd0);
        send_packet(32'd0, 20'd5);
        send_packet(32'd1, 20'd0);
        send_packet(32'd1, 20'hFFFFF);
        send_packet(32'd3, 20'd500000);
        send_packet(32'd3, 20'd500010);
        send_packet(32'd3, 20'd500020);
        send_packet(32'd3, 20'd500030);
        send_packet(32'd3, 20'd500040);
        send_packet(32'd3, 20'd500050);
        send_packet(32'd5, 20'd0);
        send_packet(32'd5, 20'd50);
        send_packet(32'd5, 20'd100);
        send_packet(32'd6, 20'd0);
        send_packet(32'hFFFF_FFFF, 20'd999999);
        send_packet(32'hFFFF_FFFF, 20'hFFFFF);
        send_packet(32'd0, 20'd0);
        resync();

        // everything close enough to join
        reconfigure(12'hFFF, 24'hFF_FFFF);
        run_random(170);

        // nothing joins
        reconfigure(12'd0, 24'd0);
        run_random(170);

        // defaults again, with one flight long enough to saturate its length
        reconfigure(RATIO_RESET, GAP_RESET);
        now_us += 2000000;
        send_at(now_us);
        repeat (262)
        begin
            now_us += 100;
            send_at(now_us);
        end
        run_random(170);

        // random thresholds; result side holds off while packets keep coming
        reconfigure(RATIO_W'($urandom_range(0, 4095)), GAP_W'($urandom_range(0, 20000)));
        hold_req = 1'b1;
        in_idle  = 1'b0;
        repeat (3) send_flight(10);
        in_idle = 1'b1;
        run_random(140);

        // drain and finish
        in_valid <= 1'b0;
        for (k = 0; k < 5000 && tracker.rtt_due.size() != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.rtt_due.size() != 0)
        begin
            $display("%0t: %0d rtt_sample_us transfers never arrived",
                     $time, tracker.rtt_due.size());
            tracker.mismatch_count++;
        end
        if (tracker.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
